// File: rtl/envelope_point_interpolator_top_assert.svh
// ----------------------------------------------------------------------------
// Envelope point interpolator assertion macros
// Shared property macros for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ENVELOPE_POINT_INTERPOLATOR_TOP_ASSERT_SVH
`define ENVELOPE_POINT_INTERPOLATOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EPI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EPI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/epi_pkg.sv
// ----------------------------------------------------------------------------
// Envelope point interpolator package
// Payload types, command and status groups, codes and level helpers.
// ----------------------------------------------------------------------------
package epi_pkg;

    localparam int LVL_W      = 17;
    localparam int POS_W      = 16;
    localparam int FRM_W      = 16;
    localparam int VAL_W      = 8;
    localparam int MODE_W     = 2;
    localparam int PIDX_W     = 4;
    localparam int REG_IDX_W  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    localparam int VALUE_FULL    = 'h40;
    localparam int LEVEL_ONE_INT = 65536;
    localparam int VALUE_SHIFT   = $clog2(LEVEL_ONE_INT / VALUE_FULL);
    localparam int WIDE_W        = LVL_W + 1;
    localparam int PROD_W        = FRM_W + VAL_W;
    localparam int DIV_STEPS     = WIDE_W;
    localparam int DCNT_W        = $clog2(DIV_STEPS);

    localparam logic [LVL_W-1:0] LEVEL_ONE = LVL_W'(LEVEL_ONE_INT);

    localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SET_POS = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ON       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_FIRST    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LAST     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_ON    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_INDEX = 3'd5;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [PIDX_W-1:0] point_index;
        logic [FRM_W-1:0]  point_frame;
        logic [VAL_W-1:0]  point_value;
        logic              key_held;
        logic [POS_W-1:0]  new_position;
        logic [LVL_W-1:0]  start_level;
    } t_in;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic [POS_W-1:0] position;
    } t_out;

    typedef struct packed {
        logic [REG_IDX_W-1:0] point_count;
        logic                 loop_on;
        logic [REG_IDX_W-1:0] loop_first;
        logic [REG_IDX_W-1:0] loop_last;
        logic                 sustain_on;
        logic [REG_IDX_W-1:0] sustain_index;
    } t_cfg;

    typedef struct packed {
        logic wr_pt;
        logic set_pos;
        logic set_lvl;
        logic cap_held;
        logic rd_en;
        logic ld_fs;
        logic ld_ls;
        logic wrap;
        logic ld_a;
        logic ld_b;
        logic lvl_one;
        logic eval;
        logic div_init;
        logic div_step;
        logic lvl_div;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic at_end;
    } t_stat;

    function automatic logic [LVL_W-1:0] clamp_level(input logic [WIDE_W-1:0] v);
        logic [LVL_W-1:0] res;
        res = (v > WIDE_W'(LEVEL_ONE_INT)) ? LEVEL_ONE : v[LVL_W-1:0];
        return res;
    endfunction

    function automatic logic [WIDE_W-1:0] scale_value(input logic [VAL_W-1:0] v);
        logic [WIDE_W-1:0] res;
        res = WIDE_W'(v) << VALUE_SHIFT;
        return res;
    endfunction

endpackage

// File: rtl/epi_dp.sv
// ----------------------------------------------------------------------------
// Envelope point interpolator datapath
// Point memory, position and level registers, products and radix-2 divider.
// ----------------------------------------------------------------------------
module epi_dp #(
    parameter int MAX_POINTS = 12,
    parameter int IW         = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  epi_pkg::t_cmd                i_cmd,
    input  logic [IW-1:0]                i_rd_addr,
    input  epi_pkg::t_in                 i_item,
    input  logic                         i_sustain_on,
    output epi_pkg::t_stat               o_stat,
    output logic [epi_pkg::LVL_W-1:0]    o_level,
    output logic [epi_pkg::POS_W-1:0]    o_position
);
    import epi_pkg::*;

    logic [FRM_W+VAL_W-1:0] r_mem [MAX_POINTS];
    logic [FRM_W-1:0]       r_rd_frame;
    logic [VAL_W-1:0]       r_rd_value;

    logic [POS_W-1:0]  r_pos;
    logic [LVL_W-1:0]  r_level;
    logic              r_held;
    logic [FRM_W-1:0]  r_fs;
    logic [FRM_W-1:0]  r_ls;
    logic [FRM_W-1:0]  r_fa;
    logic [FRM_W-1:0]  r_fb;
    logic [VAL_W-1:0]  r_va;
    logic [VAL_W-1:0]  r_vb;
    logic [PROD_W-1:0] r_pa;
    logic [PROD_W-1:0] r_pb;
    logic [FRM_W-1:0]  r_rem;
    logic [WIDE_W-1:0] r_dq;

    logic              wr_ok;
    logic [FRM_W-1:0]  loop_len;
    logic [PROD_W-1:0] prod_sum;
    logic [FRM_W-1:0]  divisor;
    logic [FRM_W:0]    trial;
    logic              trial_ge;
    logic              advance;

    assign wr_ok    = int'(i_item.point_index) < MAX_POINTS;
    assign loop_len = r_rd_frame - r_ls;
    assign prod_sum = r_pa + r_pb;
    assign divisor  = r_fb - r_fa;
    assign trial    = {r_rem, r_dq[WIDE_W-1]};
    assign trial_ge = trial >= {1'b0, divisor};
    assign advance  = !r_held || !i_sustain_on || (r_pos < r_fs);

    assign o_stat.hit    = (r_fa <= r_pos) && (r_rd_frame >= r_pos);
    assign o_stat.at_end = (r_pos <= r_fa) || (r_pos >= r_fb);
    assign o_level       = r_level;
    assign o_position    = r_pos;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_pt && wr_ok) begin
            r_mem[IW'(i_item.point_index)] <= {i_item.point_frame, i_item.point_value};
        end
        if (i_cmd.rd_en) begin
            {r_rd_frame, r_rd_value} <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_level <= LEVEL_ONE;
        end else begin
            if (i_cmd.set_pos) begin
                r_pos <= i_item.new_position;
            end else if (i_cmd.wrap && (r_pos >= r_rd_frame)) begin
                r_pos <= r_pos - loop_len;
            end else if (i_cmd.eval && advance) begin
                r_pos <= r_pos + 1'b1;
            end
            if (i_cmd.set_lvl) begin
                r_level <= clamp_level({1'b0, i_item.start_level});
            end else if (i_cmd.lvl_one) begin
                r_level <= clamp_level(scale_value(r_rd_value));
            end else if (i_cmd.eval && (r_pos <= r_fa)) begin
                r_level <= clamp_level(scale_value(r_va));
            end else if (i_cmd.eval && (r_pos >= r_fb)) begin
                r_level <= clamp_level(scale_value(r_vb));
            end else if (i_cmd.lvl_div) begin
                r_level <= clamp_level(r_dq);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_held) begin
            r_held <= i_item.key_held;
        end
        if (i_cmd.ld_fs) begin
            r_fs <= r_rd_frame;
        end
        if (i_cmd.ld_ls) begin
            r_ls <= r_rd_frame;
        end
        if (i_cmd.ld_a) begin
            r_fa <= r_rd_frame;
            r_va <= r_rd_value;
        end
        if (i_cmd.ld_b) begin
            r_fb <= r_rd_frame;
            r_vb <= r_rd_value;
        end
        if (i_cmd.eval) begin
            r_pa <= PROD_W'(r_va) * PROD_W'(r_fb - r_pos);
            r_pb <= PROD_W'(r_vb) * PROD_W'(r_pos - r_fa);
        end
        if (i_cmd.div_init) begin
            r_rem <= prod_sum[PROD_W-1 -: FRM_W];
            r_dq  <= {prod_sum[PROD_W-FRM_W-1:0], {VALUE_SHIFT{1'b0}}};
        end else if (i_cmd.div_step) begin
            r_rem <= trial_ge ? FRM_W'(trial - {1'b0, divisor}) : trial[FRM_W-1:0];
            r_dq  <= {r_dq[WIDE_W-2:0], trial_ge};
        end
    end

endmodule

// File: rtl/epi_ctrl.sv
// ----------------------------------------------------------------------------
// Envelope point interpolator controller
// Sequences item handling, point reads, segment search and division.
// ----------------------------------------------------------------------------
module epi_ctrl #(
    parameter int MAX_POINTS = 12,
    parameter int IW         = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [epi_pkg::MODE_W-1:0]    i_mode,
    input  epi_pkg::t_cfg                 i_cfg,
    input  epi_pkg::t_stat                i_stat,
    input  logic                          i_out_free,
    output epi_pkg::t_cmd                 o_cmd,
    output logic [IW-1:0]                 o_rd_addr
);
    import epi_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_ONE  = 4'd1;
    localparam logic [3:0] ST_SUS  = 4'd2;
    localparam logic [3:0] ST_LS   = 4'd3;
    localparam logic [3:0] ST_LE   = 4'd4;
    localparam logic [3:0] ST_A    = 4'd5;
    localparam logic [3:0] ST_B    = 4'd6;
    localparam logic [3:0] ST_EVAL = 4'd7;
    localparam logic [3:0] ST_DIVI = 4'd8;
    localparam logic [3:0] ST_DIV  = 4'd9;
    localparam logic [3:0] ST_LVL  = 4'd10;
    localparam logic [3:0] ST_DONE = 4'd11;

    logic [3:0]        r_state, n_state;
    logic [CW-1:0]     r_n, n_n;
    logic [CW-1:0]     r_k, n_k;
    logic [DCNT_W-1:0] r_cnt, n_cnt;

    logic [CW-1:0]     pts;

    function automatic logic [IW-1:0] clamp_idx(input logic [REG_IDX_W-1:0] i);
        logic [IW-1:0] res;
        res = (int'(i) >= MAX_POINTS) ? IW'(MAX_POINTS - 1) : IW'(i);
        return res;
    endfunction

    assign pts        = (int'(i_cfg.point_count) > MAX_POINTS) ? CW'(MAX_POINTS)
                                                               : CW'(i_cfg.point_count);
    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state   = r_state;
        n_n       = r_n;
        n_k       = r_k;
        n_cnt     = r_cnt;
        o_cmd     = '0;
        o_rd_addr = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_mode)
                        MODE_WRITE: begin
                            o_cmd.wr_pt = 1'b1;
                        end
                        MODE_SET_POS: begin
                            o_cmd.set_pos = 1'b1;
                        end
                        MODE_RESTART: begin
                            o_cmd.set_pos = 1'b1;
                            o_cmd.set_lvl = 1'b1;
                        end
                        MODE_TICK: begin
                            o_cmd.cap_held = 1'b1;
                            n_n            = pts;
                            o_cmd.rd_en    = 1'b1;
                            if (pts == '0) begin
                                n_state = ST_DONE;
                            end else if (pts == CW'(1)) begin
                                n_state = ST_ONE;
                            end else begin
                                o_rd_addr = clamp_idx(i_cfg.sustain_index);
                                n_state   = ST_SUS;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ONE: begin
                o_cmd.lvl_one = 1'b1;
                n_state       = ST_DONE;
            end
            ST_SUS: begin
                o_cmd.ld_fs = 1'b1;
                o_cmd.rd_en = 1'b1;
                if (i_cfg.loop_on) begin
                    o_rd_addr = clamp_idx(i_cfg.loop_first);
                    n_state   = ST_LS;
                end else begin
                    n_state = ST_A;
                end
            end
            ST_LS: begin
                o_cmd.ld_ls = 1'b1;
                o_cmd.rd_en = 1'b1;
                o_rd_addr   = clamp_idx(i_cfg.loop_last);
                n_state     = ST_LE;
            end
            ST_LE: begin
                o_cmd.wrap  = 1'b1;
                o_cmd.rd_en = 1'b1;
                n_state     = ST_A;
            end
            ST_A: begin
                o_cmd.ld_a  = 1'b1;
                o_cmd.rd_en = 1'b1;
                o_rd_addr   = IW'(1);
                n_k         = CW'(1);
                n_state     = ST_B;
            end
            ST_B: begin
                o_cmd.ld_b = 1'b1;
                if (i_stat.hit || (r_k == r_n - 1'b1)) begin
                    n_state = ST_EVAL;
                end else begin
                    o_cmd.ld_a  = 1'b1;
                    o_cmd.rd_en = 1'b1;
                    n_k         = r_k + 1'b1;
                    o_rd_addr   = IW'(r_k + 1'b1);
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_stat.at_end ? ST_DONE : ST_DIVI;
            end
            ST_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_LVL;
                end
            end
            ST_LVL: begin
                o_cmd.lvl_div = 1'b1;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_n     <= '0;
            r_k     <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_k     <= n_k;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// File: rtl/envelope_point_interpolator_top.sv
// ----------------------------------------------------------------------------
// Envelope point interpolator
// Per-tick piecewise linear envelope generator over a table of points.
// ----------------------------------------------------------------------------
// Items arrive on the input channel (valid/ready) and each transfer carries a
// mode: write a point, tick, set the position, or restart with a start level.
// Only a tick returns a result, a level and a position, on the output channel.
// Point writes, position loads and restarts complete on transfer, leaving the
// block idle. A tick with no points in use goes straight to its result and one
// with a single point first loads that point's level. Otherwise it reads the
// sustain frame, the loop frames when looping is on, and then one point per
// cycle while searching for the segment; a position strictly inside a segment
// then runs the 18-step restoring divider before the level is loaded.
// The output register frees the input side: a new item is taken while a
// result waits, and a stalled receiver only holds the next tick at its end.
// Configuration registers are written through the plain write port, by the user
// only while the block is idle, which the block does not enforce. After reset
// the level is full scale, the position and the configuration registers are
// zero and no result is pending; points must be written before a tick reads them.
// ----------------------------------------------------------------------------
`include "envelope_point_interpolator_top_assert.svh"

module envelope_point_interpolator_top #(
    parameter int MAX_POINTS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  epi_pkg::t_in                      i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output epi_pkg::t_out                     o_out_data,
    input  logic                              i_cfg_wr_en,
    input  logic [epi_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [epi_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import epi_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);

    t_cfg  r_cfg;
    logic  r_out_valid;
    t_out  r_out;

    t_cmd             cmd;
    t_stat            stat;
    logic [IW-1:0]    rd_addr;
    logic [LVL_W-1:0] level;
    logic [POS_W-1:0] position;
    logic             out_free;
    logic             tick_take;
    logic             other_take;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign tick_take   = i_in_valid && o_in_ready && (i_in_data.mode == MODE_TICK);
    assign other_take  = i_in_valid && o_in_ready && (i_in_data.mode != MODE_TICK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_POINT_COUNT:   r_cfg.point_count   <= i_cfg_data;
                CFG_LOOP_ON:       r_cfg.loop_on       <= i_cfg_data[0];
                CFG_LOOP_FIRST:    r_cfg.loop_first    <= i_cfg_data;
                CFG_LOOP_LAST:     r_cfg.loop_last     <= i_cfg_data;
                CFG_SUSTAIN_ON:    r_cfg.sustain_on    <= i_cfg_data[0];
                CFG_SUSTAIN_INDEX: r_cfg.sustain_index <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.out_load) begin
            r_out.level    <= level;
            r_out.position <= position;
        end
    end

    epi_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .IW         (IW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_mode     (i_in_data.mode),
        .i_cfg      (r_cfg),
        .i_stat     (stat),
        .i_out_free (out_free),
        .o_cmd      (cmd),
        .o_rd_addr  (rd_addr)
    );

    epi_dp #(
        .MAX_POINTS (MAX_POINTS),
        .IW         (IW)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_rd_addr    (rd_addr),
        .i_item       (i_in_data),
        .i_sustain_on (r_cfg.sustain_on),
        .o_stat       (stat),
        .o_level      (level),
        .o_position   (position)
    );

    `EPI_ASSERT_SAME(a_level_clamped, o_out_valid, o_out_data.level <= LEVEL_ONE, "level too high")
    `EPI_ASSERT_NEXT(a_tick_busy, tick_take, !o_in_ready, "tick did not occupy the block")
    `EPI_ASSERT_NEXT(a_no_spurious_out, other_take && !o_out_valid, !o_out_valid, "stray result")
    `EPI_ASSERT_SAME(a_load_when_free, cmd.out_load, out_free, "result overwritten")

endmodule

// File: bench/envelope_point_interpolator_top_tb.sv
// ----------------------------------------------------------------------------
// Envelope point interpolator regression bench
// A short table of directed transfers covers reset, the clamps, saturation and
// the loop and sustain paths. Randomised phases follow, each with its own
// register setting. Every tick result is checked against an in-bench envelope
// model or a table result, while both sides of the block idle and stall at random.
// ----------------------------------------------------------------------------
module envelope_point_interpolator_top_tb;

    import epi_pkg::*;

    localparam int N_POINTS        = 12;
    localparam int IDLE_PCT        = 6;
    localparam int SETTLE_CYCLES   = 64;
    localparam int HOLD_CYCLES     = 400;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 48;
    localparam int MAX_REPORTS     = 10;
    localparam int CYCLE_LIMIT     = 400000;
    localparam longint unsigned SCALE = LEVEL_ONE_INT / VALUE_FULL;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        t_in                   item;
        bit                    typed;
        t_out                  result;
    } t_dir_row;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in                   in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out                  out_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic [FRM_W-1:0] pt_frame [N_POINTS];
    logic [VAL_W-1:0] pt_value [N_POINTS];
    logic [POS_W-1:0] env_pos;
    logic [LVL_W-1:0] env_level;
    t_cfg             regs;

    t_out     awaited_ticks [$];
    t_dir_row dir_rows [$];

    bit calm        = 1'b0;
    bit rx_hold_req = 1'b0;
    int fault_count = 0;
    int items_sent  = 0;
    int ticks_seen  = 0;
    int reg_writes  = 0;

    envelope_point_interpolator_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [LVL_W-1:0] saturate_level(input longint unsigned v);
        return (v > longint'(LEVEL_ONE_INT)) ? LEVEL_ONE : v[LVL_W-1:0];
    endfunction

    function automatic logic [3:0] limit_index(input logic [3:0] i);
        return (i >= N_POINTS) ? 4'(N_POINTS - 1) : i;
    endfunction

    function automatic logic [LVL_W-1:0] segment_level(input int j, input logic [POS_W-1:0] c);
        logic [FRM_W-1:0] fa;
        logic [FRM_W-1:0] fb;
        longint unsigned  va;
        longint unsigned  vb;
        longint unsigned  d;
        longint unsigned  t;
        fa = pt_frame[j];
        fb = pt_frame[j + 1];
        va = pt_value[j];
        vb = pt_value[j + 1];
        if (c <= fa) begin
            return saturate_level(va * SCALE);
        end
        if (c >= fb) begin
            return saturate_level(vb * SCALE);
        end
        d = fb - fa;
        t = c - fa;
        return saturate_level((SCALE * (va * (d - t) + vb * t)) / d);
    endfunction

    function automatic t_out tick_envelope(input logic held);
        int               n;
        int               j;
        logic [POS_W-1:0] c;
        logic [FRM_W-1:0] ls;
        logic [FRM_W-1:0] le;
        logic [FRM_W-1:0] span;
        t_out             r;
        n = (regs.point_count > N_POINTS) ? N_POINTS : int'(regs.point_count);
        c = env_pos;
        if (n == 1) begin
            env_level = saturate_level(longint'(pt_value[0]) * SCALE);
        end else if (n >= 2) begin
            if (regs.loop_on) begin
                ls   = pt_frame[limit_index(regs.loop_first)];
                le   = pt_frame[limit_index(regs.loop_last)];
                span = le - ls;
                if (c >= le) begin
                    c = c - span;
                end
            end
            j = 0;
            while (j < n - 2 && !(pt_frame[j] <= c && pt_frame[j + 1] >= c)) begin
                j++;
            end
            env_level = segment_level(j, c);
            if (!held || !regs.sustain_on || c < pt_frame[limit_index(regs.sustain_index)]) begin
                c = c + 16'd1;
            end
            env_pos = c;
        end
        r.level    = env_level;
        r.position = env_pos;
        return r;
    endfunction

    function automatic void record_transfer(input t_in it, input bit typed, input t_out typed_res);
        t_out r;
        case (it.mode)
            MODE_WRITE: begin
                if (it.point_index < N_POINTS) begin
                    pt_frame[it.point_index] = it.point_frame;
                    pt_value[it.point_index] = it.point_value;
                end
            end
            MODE_TICK: begin
                r = tick_envelope(it.key_held);
                awaited_ticks.push_back(typed ? typed_res : r);
            end
            MODE_SET_POS: begin
                env_pos = it.new_position;
            end
            MODE_RESTART: begin
                env_pos   = it.new_position;
                env_level = saturate_level(longint'(it.start_level));
            end
            default: begin
            end
        endcase
    endfunction

    function automatic t_in mk_item(input logic [MODE_W-1:0] mode, input logic [PIDX_W-1:0] idx,
                                    input logic [FRM_W-1:0] frame, input logic [VAL_W-1:0] value,
                                    input logic held, input logic [POS_W-1:0] pos,
                                    input logic [LVL_W-1:0] lvl);
        t_in it;
        it.mode         = mode;
        it.point_index  = idx;
        it.point_frame  = frame;
        it.point_value  = value;
        it.key_held     = held;
        it.new_position = pos;
        it.start_level  = lvl;
        return it;
    endfunction

    function automatic t_in noise_item();
        return mk_item(MODE_W'($urandom), PIDX_W'($urandom), FRM_W'($urandom), VAL_W'($urandom),
                       1'($urandom), POS_W'($urandom), LVL_W'($urandom));
    endfunction

    function automatic t_out mk_result(input logic [LVL_W-1:0] lvl, input logic [POS_W-1:0] pos);
        t_out r;
        r.level    = lvl;
        r.position = pos;
        return r;
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        t_dir_row row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_item(input t_in it, input bit typed, input t_out res);
        t_dir_row row;
        row        = '{default: '0};
        row.item   = it;
        row.typed  = typed;
        row.result = res;
        dir_rows.push_back(row);
    endfunction

    function automatic void build_directed();
        logic [VAL_W-1:0] dvals [N_POINTS];
        t_out             none;
        none  = '0;
        dvals = '{8'd255, 8'd0, 8'd64, 8'd128, 8'd10, 8'd200, 8'd64, 8'd1, 8'd33, 8'd64,
                  8'd100, 8'd255};
        add_item(mk_item(MODE_TICK, 0, 0, 0, 1'b0, 0, 0), 1'b1, mk_result(LEVEL_ONE, 16'h0000));
        for (int i = 0; i < N_POINTS; i++) begin
            add_item(mk_item(MODE_WRITE, PIDX_W'(i),
                             (i == N_POINTS - 1) ? 16'hFFFF : FRM_W'(i * 100),
                             dvals[i], 1'b0, 0, 0), 1'b0, none);
        end
        add_item(mk_item(MODE_WRITE, 4'd12, 16'h5555, 8'hAA, 1'b1, 16'hFFFF, 17'h1FFFF),
                 1'b0, none);
        add_item(mk_item(MODE_WRITE, 4'd15, 16'h0000, 8'h00, 1'b0, 16'h0000, 17'h00000),
                 1'b0, none);
        add_cfg(CFG_POINT_COUNT, 4'd1);
        add_item(mk_item(MODE_TICK, 0, 0, 0, 1'b1, 0, 0), 1'b1, mk_result(LEVEL_ONE, 16'h0000));
        add_item(mk_item(MODE_RESTART, 0, 0, 0, 1'b0, 16'hFFFF, 17'h1FFFF), 1'b0, none);
        add_cfg(CFG_POINT_COUNT, 4'd0);
        add_item(mk_item(MODE_TICK, 0, 0, 0, 1'b0, 0, 0), 1'b1, mk_result(LEVEL_ONE, 16'hFFFF));
        add_item(mk_item(MODE_RESTART, 0, 0, 0, 1'b0, 16'h1234, 17'h00000), 1'b0, none);
        add_item(mk_item(MODE_TICK, 0, 0, 0, 1'b0, 0, 0), 1'b1, mk_result(17'd0, 16'h1234));
        add_cfg(CFG_POINT_COUNT, 4'd15);
        add_item(mk_item(MODE_TICK, 0, 0, 0, 1'b0, 0, 0), 1'b0, none);
        add_cfg(CFG_POINT_COUNT, 4'd4);
        add_item(mk_item(MODE_SET_POS, 0, 0, 0, 1'b0, 16'hFFFF, 0), 1'b0, none);
        add_item(mk_item(MODE_TICK, 0, 0, 0, 1'b0, 0, 0), 1'b0, none);
        add_item(mk_item(MODE_SET_POS, 0, 0, 0, 1'b0, 16'd250, 0), 1'b0, none);
        add_cfg(CFG_SUSTAIN_ON, 4'd1);
        add_cfg(CFG_SUSTAIN_INDEX, 4'd2);
        add_item(mk_item(MODE_TICK, 0, 0, 0, 1'b1, 0, 0), 1'b0, none);
        add_item(mk_item(MODE_TICK, 0, 0, 0, 1'b0, 0, 0), 1'b0, none);
        add_cfg(CFG_LOOP_ON, 4'd1);
        add_cfg(CFG_LOOP_FIRST, 4'd15);
        add_cfg(CFG_LOOP_LAST, 4'd1);
        add_item(mk_item(MODE_TICK, 0, 0, 0, 1'b1, 0, 0), 1'b0, none);
        add_item(mk_item(MODE_TICK, 0, 0, 0, 1'b0, 0, 0), 1'b0, none);
    endfunction

    task automatic send_item(input t_in it, input bit typed, input t_out typed_res);
        int gap;
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        record_transfer(it, typed, typed_res);
        items_sent++;
    endtask

    task automatic settle_block();
        in_valid <= 1'b0;
        while (awaited_ticks.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_POINT_COUNT:   regs.point_count   = val;
            CFG_LOOP_ON:       regs.loop_on       = val[0];
            CFG_LOOP_FIRST:    regs.loop_first    = val;
            CFG_LOOP_LAST:     regs.loop_last     = val;
            CFG_SUSTAIN_ON:    regs.sustain_on    = val[0];
            CFG_SUSTAIN_INDEX: regs.sustain_index = val;
            default: ;
        endcase
        reg_writes++;
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [3:0] rand_reg_index();
        return ($urandom_range(0, 7) == 0) ? 4'($urandom_range(12, 15))
                                           : 4'($urandom_range(0, 11));
    endfunction

    function automatic logic [LVL_W-1:0] rand_level();
        return ($urandom_range(0, 9) == 0) ? LVL_W'($urandom_range(65537, 131071))
                                           : LVL_W'($urandom_range(0, 65536));
    endfunction

    task automatic configure_regs(input int p);
        logic [3:0] v [6];
        if (p == 0) begin
            v = '{4'd15, 4'd1, 4'd15, 4'd15, 4'd1, 4'd15};
        end else if (p == 1) begin
            v = '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
        end else begin
            v[0] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(13, 15))
                                               : 4'($urandom_range(2, 12));
            if (p == 2) begin
                v[0] = 4'd1;
            end
            v[1] = 4'($urandom_range(0, 1));
            v[2] = rand_reg_index();
            v[3] = rand_reg_index();
            v[4] = 4'($urandom_range(0, 1));
            v[5] = rand_reg_index();
        end
        write_reg(CFG_POINT_COUNT, v[0]);
        write_reg(CFG_LOOP_ON, v[1]);
        write_reg(CFG_LOOP_FIRST, v[2]);
        write_reg(CFG_LOOP_LAST, v[3]);
        write_reg(CFG_SUSTAIN_ON, v[4]);
        write_reg(CFG_SUSTAIN_INDEX, v[5]);
    endtask

    task automatic run_phase(input int p);
        int               sent;
        int               r;
        logic [FRM_W-1:0] base;
        t_in              it;
        settle_block();
        configure_regs(p);
        calm = (p == 6);
        if (p == 4) begin
            rx_hold_req = 1'b1;
        end
        base = ($urandom_range(0, 4) == 0) ? FRM_W'($urandom) : FRM_W'($urandom_range(0, 15));
        for (int k = 0; k < N_POINTS; k++) begin
            it             = noise_item();
            it.mode        = MODE_WRITE;
            it.point_index = PIDX_W'(k);
            it.point_frame = base;
            it.point_value = ($urandom_range(0, 3) == 0) ? VAL_W'($urandom)
                                                         : VAL_W'($urandom_range(0, 64));
            send_item(it, 1'b0, '0);
            base = base + (($urandom_range(0, 7) == 0) ? FRM_W'($urandom_range(0, 4000))
                                                       : FRM_W'($urandom_range(0, 12)));
        end
        it              = noise_item();
        it.mode         = MODE_RESTART;
        it.new_position = POS_W'(pt_frame[0] + $urandom_range(0, 4) - 2);
        it.start_level  = rand_level();
        send_item(it, 1'b0, '0);
        sent = N_POINTS + 1;
        while (sent < ITEMS_PER_PHASE) begin
            r  = $urandom_range(0, 99);
            it = noise_item();
            if (r < 78) begin
                it.mode     = MODE_TICK;
                it.key_held = regs.sustain_on ? ($urandom_range(0, 99) < 75) : 1'($urandom);
            end else if (r < 90) begin
                it.mode         = (r < 86) ? MODE_SET_POS : MODE_RESTART;
                it.new_position = POS_W'(pt_frame[$urandom_range(0, N_POINTS - 1)]
                                         + $urandom_range(0, 4) - 2);
                it.start_level  = rand_level();
            end
            send_item(it, 1'b0, '0);
            sent++;
        end
        calm = 1'b0;
    endtask

    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin : result_check
        t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (awaited_ticks.size() == 0) begin
                if (fault_count < MAX_REPORTS) begin
                    $display("unexpected result: level %0d position %0d",
                             out_data.level, out_data.position);
                end
                fault_count++;
            end else begin
                want = awaited_ticks.pop_front();
                ticks_seen++;
                if (out_data.level !== want.level || out_data.position !== want.position) begin
                    if (fault_count < MAX_REPORTS) begin
                        $display("tick %0d: level exp %0d got %0d, position exp %0d got %0d",
                                 ticks_seen, want.level, out_data.level,
                                 want.position, out_data.position);
                    end
                    fault_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("envelope_point_interpolator_top regression: fail");
        $finish;
    end

    initial begin : stimulus
        bit sent_since_settle;
        for (int i = 0; i < N_POINTS; i++) begin
            pt_frame[i] = '0;
            pt_value[i] = '0;
        end
        env_pos           = '0;
        env_level         = LEVEL_ONE;
        regs              = '0;
        sent_since_settle = 1'b0;
        build_directed();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) begin
                if (sent_since_settle) begin
                    settle_block();
                    sent_since_settle = 1'b0;
                end
                write_reg(dir_rows[k].reg_idx, dir_rows[k].reg_val);
            end else begin
                send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].result);
                sent_since_settle = 1'b1;
            end
        end
        for (int p = 0; p < NUM_PHASES; p++) begin
            run_phase(p);
        end
        settle_block();
        $display("%0d transfers sent, %0d tick results checked, %0d register writes",
                 items_sent, ticks_seen, reg_writes);
        $display("%0d directed rows and %0d randomised phases, %0d mismatches",
                 dir_rows.size(), NUM_PHASES, fault_count);
        if (fault_count == 0) begin
            $display("envelope_point_interpolator_top regression: pass");
        end else begin
            $display("envelope_point_interpolator_top regression: fail");
        end
        $finish;
    end

endmodule

// File: envelope_point_interpolator_top.f
+incdir+rtl
rtl/epi_pkg.sv
rtl/epi_dp.sv
rtl/epi_ctrl.sv
rtl/envelope_point_interpolator_top.sv
bench/envelope_point_interpolator_top_tb.sv
